@@ hw/rtl/battery_discharge_capacity_meter_assert.svh @@
// assertion macros for the discharge capacity meter
// expects clk and rst_n in the scope of each use
`ifndef BATTERY_DISCHARGE_CAPACITY_METER_ASSERT_SVH
`define BATTERY_DISCHARGE_CAPACITY_METER_ASSERT_SVH

// same-cycle property, off while in reset
`define BDCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication, off while in reset
`define BDCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bdcm_pkg.sv @@
// shared types, codes and constants of the discharge capacity meter
// no dependencies
`default_nettype none

package bdcm_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 23;
  localparam int ELAPSED_W  = 23;

  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TIME    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OVERCURRENT = 2'd3;

  localparam logic [15:0]        RST_INTERVAL    = 16'd1000;
  localparam logic [22:0]        RST_MAX_TIME    = 23'd36000;
  localparam logic signed [15:0] RST_CUTOFF      = 16'sd3000;
  localparam logic signed [15:0] RST_OVERCURRENT = 16'sd2000;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_VZERO = 2'd1;
  localparam logic [1:0] CAUSE_OC    = 2'd2;
  localparam logic [1:0] CAUSE_TMO   = 2'd3;

  // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32 bit x
  localparam logic [28:0] DIV_MAGIC = 29'd274877907;
  localparam int          DIV_SHIFT = 38;

  typedef struct packed {
    logic [1:0]        command;
    logic [31:0]       time_ms;
    logic              sample_ready;
    logic signed [15:0] voltage_mv;
    logic signed [15:0] current_ma;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [1:0]         error_cause;
    logic               load_on;
    logic               sample_taken;
    logic signed [63:0] capacity_acc;
    logic signed [63:0] energy_acc;
    logic [ELAPSED_W-1:0] elapsed_s;
  } out_item_t;

  // one bit per sequencer step
  typedef struct packed {
    logic load;
    logic div;
    logic secs;
    logic flags;
    logic qmul;
    logic elo;
    logic ehi;
    logic eterm;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic integrate;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdcm_datapath.sv @@
// datapath: config registers, run state, shared multiplier and accumulators
// depends on bdcm_pkg
`default_nettype none

module bdcm_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bdcm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bdcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire bdcm_pkg::in_item_t              in_data,
  input  wire bdcm_pkg::cmd_t                  cmd,
  output bdcm_pkg::sts_t                       sts,
  output bdcm_pkg::out_item_t                  out_data
);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc,
                                                 input logic [67:0] term);
    logic [67:0] s;
    s = {{4{acc[63]}}, acc} + term;
    if (s[67:63] == 5'b00000 || s[67:63] == 5'b11111) begin
      return s[63:0];
    end else if (s[67]) begin
      return {1'b1, 63'd0};
    end else begin
      return {1'b0, {63{1'b1}}};
    end
  endfunction

  // configuration
  logic [15:0]        interval_r;
  logic [22:0]        max_time_r;
  logic signed [15:0] cutoff_r;
  logic signed [15:0] ovc_r;

  // run state
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         cause_r, cause_nxt;
  logic signed [63:0] charge_r, charge_nxt;
  logic signed [63:0] energy_r, energy_nxt;
  logic signed [15:0] lc_r, lc_nxt;
  logic signed [15:0] lv_r, lv_nxt;
  logic [31:0]        start_r, start_nxt;
  logic [31:0]        lss_r, lss_nxt;
  logic [31:0]        ltick_r, ltick_nxt;

  // working registers
  bdcm_pkg::in_item_t  item_r;
  bdcm_pkg::out_item_t out_r;
  logic signed [66:0]  prod_r;
  logic [bdcm_pkg::ELAPSED_W-1:0] secs_r;
  logic [31:0]        pv0_r;
  logic signed [33:0] psum_r;
  logic [49:0]        qterm_r;
  logic [50:0]        elo_r;
  logic [66:0]        eterm_r;
  logic               tick_ok_r;
  logic               take_r;
  logic               integ_r;
  logic [1:0]         fault_r;

  logic               start_ok;
  logic [31:0]        diff;
  logic [31:0]        dt;
  logic [31:0]        tick_gap;
  logic [16:0]        isum;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  logic               tick_ok_c;
  logic [1:0]         fault_c;
  logic               take_c;
  logic               first_c;
  logic               integ_c;

  assign start_ok = (item_r.command == bdcm_pkg::CMD_START) && (phase_r != bdcm_pkg::PH_RUN);
  assign diff     = start_ok ? 32'd0 : (item_r.time_ms - start_r);
  assign dt       = item_r.time_ms - lss_r;
  assign tick_gap = item_r.time_ms - ltick_r;
  assign isum     = {lc_r[15], lc_r} + {item_r.current_ma[15], item_r.current_ma};

  always_comb begin
    priority if (cmd.div) begin
      mul_a = {2'b00, diff};
      mul_b = {4'b0000, bdcm_pkg::DIV_MAGIC};
    end else if (cmd.secs) begin
      mul_a = {{18{lv_r[15]}}, lv_r};
      mul_b = {{17{lc_r[15]}}, lc_r};
    end else if (cmd.flags) begin
      mul_a = {{18{item_r.voltage_mv[15]}}, item_r.voltage_mv};
      mul_b = {{17{item_r.current_ma[15]}}, item_r.current_ma};
    end else if (cmd.qmul) begin
      mul_a = {{17{isum[16]}}, isum};
      mul_b = {1'b0, dt};
    end else if (cmd.elo) begin
      mul_a = psum_r;
      mul_b = {17'd0, dt[15:0]};
    end else begin
      mul_a = psum_r;
      mul_b = {17'd0, dt[31:16]};
    end
  end

  assign prod = mul_a * mul_b;

  // fault and throttle decision, valid in the flags step
  always_comb begin
    tick_ok_c = (item_r.command == bdcm_pkg::CMD_SAMPLE) && (phase_r == bdcm_pkg::PH_RUN) &&
                !((ltick_r != 32'd0) && (tick_gap < {16'd0, interval_r}));
    priority if (item_r.voltage_mv == 16'sd0) begin
      fault_c = bdcm_pkg::CAUSE_VZERO;
    end else if ($signed(item_r.current_ma) > $signed(ovc_r)) begin
      fault_c = bdcm_pkg::CAUSE_OC;
    end else if (secs_r > max_time_r) begin
      fault_c = bdcm_pkg::CAUSE_TMO;
    end else begin
      fault_c = bdcm_pkg::CAUSE_NONE;
    end
    take_c  = tick_ok_c && item_r.sample_ready && (fault_c == bdcm_pkg::CAUSE_NONE);
    first_c = (lss_r == start_r) && (lc_r == 16'sd0);
    integ_c = take_c && !first_c;
  end

  assign sts.integrate = integ_c;

  always_comb begin
    phase_nxt  = phase_r;
    cause_nxt  = cause_r;
    charge_nxt = charge_r;
    energy_nxt = energy_r;
    lc_nxt     = lc_r;
    lv_nxt     = lv_r;
    start_nxt  = start_r;
    lss_nxt    = lss_r;
    ltick_nxt  = ltick_r;
    if (cmd.commit) begin
      priority if (start_ok) begin
        charge_nxt = 64'sd0;
        energy_nxt = 64'sd0;
        lc_nxt     = 16'sd0;
        lv_nxt     = 16'sd0;
        start_nxt  = item_r.time_ms;
        lss_nxt    = item_r.time_ms;
        ltick_nxt  = 32'd0;
        cause_nxt  = bdcm_pkg::CAUSE_NONE;
        phase_nxt  = bdcm_pkg::PH_RUN;
      end else if (item_r.command == bdcm_pkg::CMD_STOP) begin
        if (phase_r == bdcm_pkg::PH_RUN) begin
          phase_nxt = bdcm_pkg::PH_IDLE;
        end
      end else if (tick_ok_r) begin
        ltick_nxt = item_r.time_ms;
        if (item_r.sample_ready) begin
          if (fault_r != bdcm_pkg::CAUSE_NONE) begin
            phase_nxt = bdcm_pkg::PH_ERR;
            cause_nxt = fault_r;
          end else begin
            if (integ_r) begin
              charge_nxt = sat_add(charge_r, {{18{qterm_r[49]}}, qterm_r});
              energy_nxt = sat_add(energy_r, {eterm_r[66], eterm_r});
            end
            lc_nxt  = item_r.current_ma;
            lv_nxt  = item_r.voltage_mv;
            lss_nxt = item_r.time_ms;
            if ($signed(item_r.voltage_mv) < $signed(cutoff_r)) begin
              phase_nxt = bdcm_pkg::PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= bdcm_pkg::RST_INTERVAL;
      max_time_r <= bdcm_pkg::RST_MAX_TIME;
      cutoff_r   <= bdcm_pkg::RST_CUTOFF;
      ovc_r      <= bdcm_pkg::RST_OVERCURRENT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bdcm_pkg::REG_INTERVAL:    interval_r <= cfg_wdata[15:0];
        bdcm_pkg::REG_MAX_TIME:    max_time_r <= cfg_wdata[22:0];
        bdcm_pkg::REG_CUTOFF:      cutoff_r   <= cfg_wdata[15:0];
        bdcm_pkg::REG_OVERCURRENT: ovc_r      <= cfg_wdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bdcm_pkg::PH_IDLE;
      cause_r  <= bdcm_pkg::CAUSE_NONE;
      charge_r <= 64'sd0;
      energy_r <= 64'sd0;
      lc_r     <= 16'sd0;
      lv_r     <= 16'sd0;
      start_r  <= 32'd0;
      lss_r    <= 32'd0;
      ltick_r  <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      cause_r  <= cause_nxt;
      charge_r <= charge_nxt;
      energy_r <= energy_nxt;
      lc_r     <= lc_nxt;
      lv_r     <= lv_nxt;
      start_r  <= start_nxt;
      lss_r    <= lss_nxt;
      ltick_r  <= ltick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    prod_r <= prod;
    if (cmd.secs) begin
      secs_r <= prod_r[bdcm_pkg::DIV_SHIFT +: bdcm_pkg::ELAPSED_W];
    end
    if (cmd.flags) begin
      pv0_r     <= prod_r[31:0];
      tick_ok_r <= tick_ok_c;
      take_r    <= take_c;
      integ_r   <= integ_c;
      fault_r   <= fault_c;
    end
    if (cmd.qmul) begin
      psum_r <= {{2{pv0_r[31]}}, pv0_r} + {{2{prod_r[31]}}, prod_r[31:0]};
    end
    if (cmd.elo) begin
      qterm_r <= prod_r[49:0];
    end
    if (cmd.ehi) begin
      elo_r <= prod_r[50:0];
    end
    if (cmd.eterm) begin
      eterm_r <= {prod_r[50:0], 16'd0} + {{16{elo_r[50]}}, elo_r};
    end
    if (cmd.commit) begin
      out_r.phase        <= phase_nxt;
      out_r.error_cause  <= cause_nxt;
      out_r.load_on      <= (phase_nxt == bdcm_pkg::PH_RUN);
      out_r.sample_taken <= tick_ok_r && take_r;
      out_r.capacity_acc <= charge_nxt;
      out_r.energy_acc   <= energy_nxt;
      out_r.elapsed_s    <= (phase_nxt == bdcm_pkg::PH_IDLE && start_nxt == 32'd0) ?
                            '0 : secs_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ hw/rtl/bdcm_ctrl.sv @@
// controller: step sequencer and output handshake
// depends on bdcm_pkg and the assertion macro header
`default_nettype none
`include "battery_discharge_capacity_meter_assert.svh"

module bdcm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire bdcm_pkg::sts_t sts,
  output bdcm_pkg::cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_SECS   = 4'd2;
  localparam logic [3:0] ST_FLAGS  = 4'd3;
  localparam logic [3:0] ST_QMUL   = 4'd4;
  localparam logic [3:0] ST_ELO    = 4'd5;
  localparam logic [3:0] ST_EHI    = 4'd6;
  localparam logic [3:0] ST_ETERM  = 4'd7;
  localparam logic [3:0] ST_COMMIT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   state_nxt = ST_SECS;
      ST_SECS:  state_nxt = ST_FLAGS;
      ST_FLAGS: state_nxt = sts.integrate ? ST_QMUL : ST_COMMIT;
      ST_QMUL:  state_nxt = ST_ELO;
      ST_ELO:   state_nxt = ST_EHI;
      ST_EHI:   state_nxt = ST_ETERM;
      ST_ETERM: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.div    = (state_r == ST_DIV);
    cmd.secs   = (state_r == ST_SECS);
    cmd.flags  = (state_r == ST_FLAGS);
    cmd.qmul   = (state_r == ST_QMUL);
    cmd.elo    = (state_r == ST_ELO);
    cmd.ehi    = (state_r == ST_EHI);
    cmd.eterm  = (state_r == ST_ETERM);
    cmd.commit = (state_r == ST_COMMIT) && slot_free;
  end

  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `BDCM_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == ST_DIV, "accept did not start")
  `BDCM_ASSERT(a_rose_after_commit, !$rose(out_valid_r) || $past(state_r) == ST_COMMIT, "item without commit")
  `BDCM_ASSERT_NXT(a_skip_integrate, state_r == ST_FLAGS && !sts.integrate, state_r == ST_COMMIT, "bad skip")
  `BDCM_ASSERT_NXT(a_held_result, out_valid_r && out_stall && state_r == ST_COMMIT, state_r == ST_COMMIT, "overwrote held item")

endmodule

`default_nettype wire

@@ hw/rtl/battery_discharge_capacity_meter.sv @@
// Discharge capacity meter. Each accepted item (start, stop or sample tick) yields one
// result item. Start, stop and ignored or faulting sample items pass the div, secs and
// flags steps to commit; an integrating sample also passes qmul, elo, ehi and eterm. The
// single shared 34x33 multiplier does one product per cycle, save while a commit waits:
// the divide by 1000 for elapsed seconds, the two power products, the charge term and
// the two halves of the energy term. The result sits in an output register, so the next
// item is taken while a result still waits; a commit waits only while that register is
// full and stalled. Capacity and energy sums saturate at the signed 64 bit limits.
// depends on bdcm_pkg, bdcm_ctrl and bdcm_datapath
`default_nettype none

module battery_discharge_capacity_meter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire bdcm_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output bdcm_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [bdcm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bdcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bdcm_pkg::cmd_t cmd;
  bdcm_pkg::sts_t sts;

  bdcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdcm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
